// ===== rtl/chd_pkg.sv =====
// chd_pkg: shared types, constants and helpers for the chunk header deframer
`default_nettype none
package chd_pkg;

    localparam int LONG_HEADER_BYTES  = 24;
    localparam int SHORT_HEADER_BYTES = 16;
    localparam int HDR_POS_W          = 5;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_ERROR   = 2'd2
    } chd_kind_t;

    typedef logic [LONG_HEADER_BYTES-1:0][7:0] chd_hdr_t;

    typedef struct packed {
        chd_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic        hdr_short;
        logic [31:0] chunk_word;
        logic [63:0] ident;
        logic [63:0] msg_length;
        logic [31:0] length;
    } chd_entry_t;

    typedef struct packed {
        chd_kind_t   kind;
        logic [7:0]  data;
        logic        first;
        logic [30:0] number;
        logic [63:0] ident;
        logic [63:0] total;
        logic [31:0] payload_length;
        logic        last;
    } chd_out_t;

    function automatic logic short_hdr(input logic ver, input logic [31:0] cw);
        return (ver == 1'b0) && !(cw[0] && (cw[31:1] > 31'd1));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/chd_if.sv =====
// chd_if: request channel interfaces for the byte stream and the results
`default_nettype none
interface chd_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface chd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  content_byte;
    logic        first_chunk;
    logic [30:0] chunk_number;
    logic [63:0] message_ident;
    logic [63:0] total_length;
    logic [31:0] payload_length;
    logic        last_of_chunk;

    modport source (output valid, output result_kind, output content_byte,
                    output first_chunk, output chunk_number, output message_ident,
                    output total_length, output payload_length, output last_of_chunk,
                    input ready);
    modport sink   (input valid, input result_kind, input content_byte,
                    input first_chunk, input chunk_number, input message_ident,
                    input total_length, input payload_length, input last_of_chunk,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/chd_front.sv =====
// chd_front: header collection, chunk tracking and result classification
`default_nettype none
module chd_front import chd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    chd_stream_if.sink  stream,
    output chd_entry_t  push_entry,
    output logic        push_valid,
    input  wire logic   push_ready
);

    logic                 ver_reg;
    logic                 in_payload_reg, in_payload_next;
    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [31:0]          bytes_left_reg, bytes_left_next;
    chd_hdr_t             hdr_reg, hdr_next;

    logic                 accept;
    logic [HDR_POS_W-1:0] pos_eff;
    logic [HDR_POS_W-1:0] pos_inc;
    chd_hdr_t             hdr_fill;
    logic [31:0]          len_new;
    logic [31:0]          cw_new;
    logic                 end_short;
    logic                 end_long;
    logic [31:0]          hdr_len;
    logic                 len_err;

    assign stream.ready = push_ready;
    assign accept       = stream.valid && push_ready;

    always_comb
    begin
        pos_eff = (hdr_pos_reg >= HDR_POS_W'(LONG_HEADER_BYTES)) ? '0 : hdr_pos_reg;
        pos_inc = pos_eff + HDR_POS_W'(1);
        hdr_fill = (pos_eff == '0) ? '0 : hdr_reg;
        for (int i = 0; i < LONG_HEADER_BYTES; i++)
        begin
            if (pos_eff == HDR_POS_W'(i))
            begin
                hdr_fill[i] = stream.stream_byte;
            end
        end
        len_new   = hdr_fill[3:0];
        cw_new    = hdr_fill[7:4];
        end_short = (pos_inc == HDR_POS_W'(SHORT_HEADER_BYTES)) && short_hdr(ver_reg, cw_new);
        end_long  = (pos_inc == HDR_POS_W'(LONG_HEADER_BYTES));
        hdr_len   = end_short ? 32'(SHORT_HEADER_BYTES) : 32'(LONG_HEADER_BYTES);
        len_err   = len_new < hdr_len;

        in_payload_next = in_payload_reg;
        hdr_pos_next    = hdr_pos_reg;
        bytes_left_next = bytes_left_reg;
        hdr_next        = hdr_reg;
        push_valid      = 1'b0;
        push_entry      = '0;

        if (accept)
        begin
            if (in_payload_reg)
            begin
                push_valid            = 1'b1;
                push_entry.kind       = KIND_CONTENT;
                push_entry.data       = stream.stream_byte;
                push_entry.last       = bytes_left_reg <= 32'd1;
                push_entry.hdr_short  = short_hdr(ver_reg, hdr_reg[7:4]);
                push_entry.chunk_word = hdr_reg[7:4];
                push_entry.ident      = hdr_reg[15:8];
                push_entry.msg_length = hdr_reg[23:16];
                push_entry.length     = hdr_reg[3:0];
                if (bytes_left_reg <= 32'd1)
                begin
                    bytes_left_next = '0;
                    in_payload_next = 1'b0;
                    hdr_pos_next    = '0;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 32'd1;
                end
            end
            else
            begin
                hdr_next = hdr_fill;
                if (end_short || end_long)
                begin
                    hdr_pos_next          = '0;
                    push_valid            = 1'b1;
                    push_entry.kind       = len_err ? KIND_ERROR : KIND_HEADER;
                    push_entry.last       = !len_err && (len_new == hdr_len);
                    push_entry.hdr_short  = end_short;
                    push_entry.chunk_word = cw_new;
                    push_entry.ident      = hdr_fill[15:8];
                    push_entry.msg_length = hdr_fill[23:16];
                    push_entry.length     = len_new;
                    if (!len_err && (len_new != hdr_len))
                    begin
                        in_payload_next = 1'b1;
                        bytes_left_next = len_new - hdr_len;
                    end
                end
                else
                begin
                    hdr_pos_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_reg        <= 1'b1;
            in_payload_reg <= 1'b0;
            hdr_pos_reg    <= '0;
            bytes_left_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ver_reg <= cfg_wr_data;
            end
            in_payload_reg <= in_payload_next;
            hdr_pos_reg    <= hdr_pos_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

    // payload phase only starts from a finished header
    assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (hdr_pos_reg == '0 && bytes_left_reg != '0))
        else $error("payload phase with header position or empty count");

    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg < HDR_POS_W'(LONG_HEADER_BYTES))
        else $error("header position beyond long header");

endmodule
`default_nettype wire

// ===== rtl/chd_queue.sv =====
// chd_queue: short result queue between the front and back parts
`default_nettype none
module chd_queue import chd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire chd_entry_t  push_entry,
    input  wire logic        push_valid,
    output logic             push_ready,
    output chd_entry_t       pop_entry,
    output logic             pop_valid,
    input  wire logic        pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    chd_entry_t         slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue occupancy lost a request");

endmodule
`default_nettype wire

// ===== rtl/chd_back.sv =====
// chd_back: result formatting and registered output stage
`default_nettype none
module chd_back import chd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire chd_entry_t  pop_entry,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    chd_result_if.source     result
);

    logic        valid_reg;
    chd_out_t    out_reg, out_next;
    logic [31:0] hdr_len;

    assign pop_ready = !valid_reg || result.ready;

    always_comb
    begin
        hdr_len = pop_entry.hdr_short ? 32'(SHORT_HEADER_BYTES) : 32'(LONG_HEADER_BYTES);
        out_next.kind   = pop_entry.kind;
        out_next.data   = pop_entry.data;
        out_next.first  = pop_entry.chunk_word[0];
        out_next.number = pop_entry.chunk_word[31:1];
        out_next.ident  = pop_entry.ident;
        out_next.total  = pop_entry.msg_length;
        out_next.last   = pop_entry.last;
        if (pop_entry.kind == KIND_ERROR || pop_entry.length < hdr_len)
        begin
            out_next.payload_length = '0;
        end
        else
        begin
            out_next.payload_length = pop_entry.length - hdr_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid          = valid_reg;
    assign result.result_kind    = out_reg.kind;
    assign result.content_byte   = out_reg.data;
    assign result.first_chunk    = out_reg.first;
    assign result.chunk_number   = out_reg.number;
    assign result.message_ident  = out_reg.ident;
    assign result.total_length   = out_reg.total;
    assign result.payload_length = out_reg.payload_length;
    assign result.last_of_chunk  = out_reg.last;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_reg.kind == KIND_ERROR) |->
            (out_reg.payload_length == '0 && !out_reg.last && out_reg.data == '0))
        else $error("error request carries payload fields");

endmodule
`default_nettype wire

// ===== rtl/chunk_header_deframer.sv =====
// chunk_header_deframer: top level, byte stream in, header and content requests out
// a result is held in the result queue and then in the registered output stage after its byte is accepted
// throughput: one byte per cycle; stream ready follows the result queue not being full
// header bytes give no result; the final header byte gives one header or error result
// reset: asynchronous, clears parser to header collection and sets protocol version 1.1
`default_nettype none
module chunk_header_deframer import chd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_wr_en,
    input  wire logic     cfg_wr_data,
    chd_stream_if.sink    stream,
    chd_result_if.source  result
);

    chd_entry_t push_entry;
    logic       push_valid;
    logic       push_ready;
    chd_entry_t pop_entry;
    logic       pop_valid;
    logic       pop_ready;

    chd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (stream),
        .push_entry  (push_entry),
        .push_valid  (push_valid),
        .push_ready  (push_ready)
    );

    chd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    chd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule
`default_nettype wire

// ===== tb/tb_chunk_header_deframer.sv =====
// tb_chunk_header_deframer: directed and random chunk streams checked against a local parser model
module tb_chunk_header_deframer;
    import chd_pkg::*;

    localparam int RANDOM_BYTES   = 720;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 50;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    chd_stream_if stream_if();
    chd_result_if result_if();

    chunk_header_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (stream_if),
        .result      (result_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser state as the block should hold it
    logic        p_version;
    logic        p_in_payload;
    logic [4:0]  p_pos;
    logic [31:0] p_length;
    logic [31:0] p_chunk_word;
    logic [63:0] p_ident;
    logic [63:0] p_msg_length;
    logic [31:0] p_bytes_left;

    chd_out_t expected_results[$];
    int       mismatches;
    int       stall_cycles;
    bit       idle_enabled;

    function automatic logic takes_short_header(input logic ver, input logic [31:0] word);
        if (ver)
            return 1'b0;
        return !(word[0] && (word[31:1] >= 31'd2));
    endfunction

    function automatic int header_bytes(input logic ver, input logic [31:0] word);
        return takes_short_header(ver, word) ? SHORT_HEADER_BYTES : LONG_HEADER_BYTES;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        chd_out_t    r;
        logic [31:0] hlen;
        int          pos;
        r = '0;
        r.first = p_chunk_word[0];
        if (p_in_payload)
        begin
            r.kind   = KIND_CONTENT;
            r.data   = b;
            r.number = p_chunk_word[31:1];
            r.ident  = p_ident;
            r.total  = p_msg_length;
            hlen     = header_bytes(p_version, p_chunk_word);
            r.payload_length = (p_length >= hlen) ? p_length - hlen : 32'd0;
            r.last   = (p_bytes_left <= 32'd1);
            if (r.last)
            begin
                p_in_payload = 1'b0;
                p_bytes_left = '0;
                p_pos        = '0;
            end
            else
                p_bytes_left = p_bytes_left - 32'd1;
            expected_results.insert(expected_results.size(), r);
            return;
        end
        pos = int'(p_pos);
        if (pos >= LONG_HEADER_BYTES)
            pos = 0;
        if (pos == 0)
        begin
            p_length     = '0;
            p_chunk_word = '0;
            p_ident      = '0;
            p_msg_length = '0;
        end
        if (pos < 4)
            p_length[8*pos +: 8] = b;
        else if (pos < 8)
            p_chunk_word[8*(pos-4) +: 8] = b;
        else if (pos < 16)
            p_ident[8*(pos-8) +: 8] = b;
        else
            p_msg_length[8*(pos-16) +: 8] = b;
        pos++;
        if (pos == SHORT_HEADER_BYTES && takes_short_header(p_version, p_chunk_word))
            hlen = SHORT_HEADER_BYTES;
        else if (pos == LONG_HEADER_BYTES)
            hlen = LONG_HEADER_BYTES;
        else
        begin
            p_pos = pos[4:0];
            return;
        end
        p_pos    = '0;
        r.first  = p_chunk_word[0];
        r.number = p_chunk_word[31:1];
        r.ident  = p_ident;
        r.total  = p_msg_length;
        if (p_length < hlen)
            r.kind = KIND_ERROR;
        else
        begin
            r.kind = KIND_HEADER;
            r.payload_length = p_length - hlen;
            if (p_length == hlen)
                r.last = 1'b1;
            else
            begin
                p_in_payload = 1'b1;
                p_bytes_left = p_length - hlen;
            end
        end
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        chd_out_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected request, kind", 64'(result_if.result_kind), 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (result_if.result_kind !== want.kind)
                    report_mismatch("result_kind", 64'(result_if.result_kind), 64'(want.kind));
                if (result_if.content_byte !== want.data)
                    report_mismatch("content_byte", 64'(result_if.content_byte),
                                    64'(want.data));
                if (result_if.first_chunk !== want.first)
                    report_mismatch("first_chunk", 64'(result_if.first_chunk),
                                    64'(want.first));
                if (result_if.chunk_number !== want.number)
                    report_mismatch("chunk_number", 64'(result_if.chunk_number),
                                    64'(want.number));
                if (result_if.message_ident !== want.ident)
                    report_mismatch("message_ident", result_if.message_ident, want.ident);
                if (result_if.total_length !== want.total)
                    report_mismatch("total_length", result_if.total_length, want.total);
                if (result_if.payload_length !== want.payload_length)
                    report_mismatch("payload_length", 64'(result_if.payload_length),
                                    64'(want.payload_length));
                if (result_if.last_of_chunk !== want.last)
                    report_mismatch("last_of_chunk", 64'(result_if.last_of_chunk),
                                    64'(want.last));
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
        result_if.ready <= !(idle_enabled && $urandom_range(99) < 12);

    always @(posedge clk)
    begin
        if (!rst_n || (stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_byte(input logic [7:0] b);
        while (idle_enabled && $urandom_range(99) < 12)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        deframe_byte(b);
        @(negedge clk);
    endtask

    task automatic send_le(input logic [63:0] value, input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(value[8*i +: 8]);
    endtask

    task automatic send_chunk(input logic [31:0] len, input logic [31:0] word,
                              input logic [63:0] ident, input logic [63:0] msg_len,
                              input int hlen, input int pay);
        send_le(64'(len), 4);
        send_le(64'(word), 4);
        send_le(ident, 8);
        if (hlen == LONG_HEADER_BYTES)
            send_le(msg_len, 8);
        repeat (pay)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        stream_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_version(input logic v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        p_version = v;
    endtask

    task automatic test_long_header_chunks();
        // empty payload, all-ones fields
        send_chunk(32'd24, 32'hFFFF_FFFF, '1, '1, LONG_HEADER_BYTES, 0);
        send_chunk(32'd27, 32'h0000_0003, '0, '0, LONG_HEADER_BYTES, 3);
        // lengths shorter than the header
        send_chunk(32'd0, 32'h0000_0004, 64'h0123_4567_89AB_CDEF, 64'h55, LONG_HEADER_BYTES, 0);
        send_chunk(32'd23, 32'h0000_0001, 64'hFEDC_BA98_7654_3210, 64'hAA, LONG_HEADER_BYTES, 0);
    endtask

    task automatic test_short_header_chunks();
        set_version(1'b0);
        send_chunk(32'd16, 32'h0000_0004, 64'h1111, 64'h0, SHORT_HEADER_BYTES, 0);
        send_chunk(32'd26, 32'h0000_0005, 64'h2222, 64'hFFFF, LONG_HEADER_BYTES, 2);
        send_chunk(32'd18, 32'h0000_0003, 64'h3333, 64'h0, SHORT_HEADER_BYTES, 2);
        send_chunk(32'd15, 32'h0000_0000, 64'h4444, 64'h0, SHORT_HEADER_BYTES, 0);
        // long form chosen, but length only covers a short header
        send_chunk(32'd20, 32'h0000_0005, 64'h5555, 64'h77, LONG_HEADER_BYTES, 0);
    endtask

    task automatic test_version_change_mid_header();
        // 1.0 would stop at 16 bytes, switch to 1.1 before the decision
        send_le(64'd30, 4);
        send_le(64'd2, 4);
        send_le(64'hA1A2_A3A4_A5A6_A7A8, 2);
        set_version(1'b1);
        send_le(64'hA1A2_A3A4_A5A6, 6);
        send_le(64'h0000_0000_0000_0123, 8);
        repeat (6)
            send_byte(8'($urandom_range(255)));
        // and the other way round
        send_le(64'd17, 4);
        send_le(64'd2, 4);
        send_le(64'hB1B2, 2);
        set_version(1'b0);
        send_le(64'hB3B4_B5B6_B7B8, 6);
        send_byte(8'hFF);
    endtask

    task automatic test_random_chunks();
        int          sent;
        int          hlen;
        int          pay;
        logic [31:0] len;
        logic [31:0] word;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            idle_enabled = !(sent > RANDOM_BYTES / 3 && sent < RANDOM_BYTES / 2);
            if ($urandom_range(9) == 0)
                set_version(1'($urandom_range(1)));
            case ($urandom_range(3))
                0: word = {31'($urandom_range(40, 2)), 1'b1};
                1: word = {31'($urandom_range(1)), 1'b1};
                2: word = {31'($urandom_range(50)), 1'b0};
                default: word = $urandom();
            endcase
            hlen = header_bytes(p_version, word);
            if ($urandom_range(99) < 10)
            begin
                len = $urandom_range(hlen - 1);
                pay = 0;
            end
            else
            begin
                pay = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12);
                len = hlen + pay;
            end
            send_chunk(len, word, {$urandom(), $urandom()}, {$urandom(), $urandom()}, hlen, pay);
            sent += hlen + pay;
        end
        idle_enabled = 1'b1;
    endtask

    task automatic test_endless_chunk();
        set_version(1'b1);
        send_chunk(32'hFFFF_FFFF, 32'hFFFF_FFFE, '1, '1, LONG_HEADER_BYTES, 40);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 1'b0;
        stream_if.valid       = 1'b0;
        stream_if.stream_byte = 8'd0;
        result_if.ready       = 1'b0;
        idle_enabled          = 1'b1;
        mismatches            = 0;
        stall_cycles          = 0;
        p_version             = 1'b1;
        p_in_payload          = 1'b0;
        p_pos                 = '0;
        p_length              = '0;
        p_chunk_word          = '0;
        p_ident               = '0;
        p_msg_length          = '0;
        p_bytes_left          = '0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_long_header_chunks();
        test_short_header_chunks();
        test_version_change_mid_header();
        test_random_chunks();
        test_endless_chunk();
        wait_drained();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
